// File: rtl/ssrt_pkg.sv
`timescale 1ns / 1ps

package ssrt_pkg;

  // Shared serial arithmetic unit widths.
  localparam int OP_W   = 24;
  localparam int PROD_W = 2 * OP_W;
  localparam int CNT_W  = $clog2(OP_W);

  // Field widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DRIVE_W    = 16;
  localparam int POWER_W    = 15;
  localparam int SPEED_W    = 25;
  localparam int LIMIT_W    = 16;
  localparam int THRUST_W   = 24;
  localparam int EFF_MAG_W  = 15;

  // Fixed-point scaling.
  localparam int FRAC_W     = 14;  // Q2.14 product back to Q2.14
  localparam int TGT_SHIFT  = 6;   // eff * rpm / 64 gives 1/256 rpm
  localparam int STEP_SHIFT = 16;  // rate * tick >> 16 gives 1/256 rpm
  localparam int RPM_FRAC_W = 8;   // 1/256 rpm units

  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -16'sd16384;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sd16384;
  localparam logic [POWER_W-1:0]        POWER_MAX = 15'd16384;

  // Register reset values.
  localparam logic [LIMIT_W-1:0]  RST_FWD_SPEED  = 16'd1000;
  localparam logic [LIMIT_W-1:0]  RST_REV_SPEED  = 16'd1000;
  localparam logic [THRUST_W-1:0] RST_FWD_THRUST = 24'd10000;
  localparam logic [THRUST_W-1:0] RST_REV_THRUST = 24'd10000;
  localparam logic [LIMIT_W-1:0]  RST_SPIN_UP    = 16'd100;
  localparam logic [LIMIT_W-1:0]  RST_SPIN_DOWN  = 16'd100;
  localparam logic [THRUST_W-1:0] RST_TICK       = 24'd279620;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FWD_SPEED  = 3'd0,
    REG_REV_SPEED  = 3'd1,
    REG_FWD_THRUST = 3'd2,
    REG_REV_THRUST = 3'd3,
    REG_SPIN_UP    = 3'd4,
    REG_SPIN_DOWN  = 3'd5,
    REG_TICK       = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_CFG   = 2'd1,
    STAT_BAD_CMD   = 2'd2,
    STAT_BAD_SPEED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EFF,
    S_TGT,
    S_STEP,
    S_NEXT,
    S_TH_X,
    S_TH_Q1,
    S_TH_QA,
    S_TH_RA,
    S_TH_RD,
    S_TH_SUM,
    S_DONE
  } state_t;

endpackage

// File: rtl/shaft_speed_ramp_thrust_core.sv
`timescale 1ns / 1ps

// A command word with a nonzero new speed runs the full path of nine arithmetic operations;
// a zero new speed skips the thrust operations, and a failed check goes straight to the result.
// Words are taken one at a time: cmd_stall stays high until the result is handed off, as the
// single serial multiplier and serial divider are shared by all operations.
// Reset: synchronous, active high; registers return to their defaults and shaft speed to zero.
module shaft_speed_ramp_thrust_core import ssrt_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration write port.
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  // Command channel.
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  logic signed [DRIVE_W-1:0]  requested_drive,
  input  logic [POWER_W-1:0]         available_power,
  // Result channel.
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic signed [SPEED_W-1:0]  next_speed,
  output logic signed [DRIVE_W-1:0]  effective_drive,
  output logic signed [SPEED_W-1:0]  target_speed,
  output logic signed [SPEED_W-1:0]  thrust,
  output logic [1:0]                 status
);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0]  max_forward_speed;
  logic [LIMIT_W-1:0]  max_reverse_speed;
  logic [THRUST_W-1:0] max_forward_thrust;
  logic [THRUST_W-1:0] max_reverse_thrust;
  logic [LIMIT_W-1:0]  spin_up_rate;
  logic [LIMIT_W-1:0]  spin_down_rate;
  logic [THRUST_W-1:0] tick_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_forward_speed  <= RST_FWD_SPEED;
      max_reverse_speed  <= RST_REV_SPEED;
      max_forward_thrust <= RST_FWD_THRUST;
      max_reverse_thrust <= RST_REV_THRUST;
      spin_up_rate       <= RST_SPIN_UP;
      spin_down_rate     <= RST_SPIN_DOWN;
      tick_length        <= RST_TICK;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FWD_SPEED:  max_forward_speed  <= cfg_data[LIMIT_W-1:0];
        REG_REV_SPEED:  max_reverse_speed  <= cfg_data[LIMIT_W-1:0];
        REG_FWD_THRUST: max_forward_thrust <= cfg_data[THRUST_W-1:0];
        REG_REV_THRUST: max_reverse_thrust <= cfg_data[THRUST_W-1:0];
        REG_SPIN_UP:    spin_up_rate       <= cfg_data[LIMIT_W-1:0];
        REG_SPIN_DOWN:  spin_down_rate     <= cfg_data[LIMIT_W-1:0];
        REG_TICK:       tick_length        <= cfg_data[THRUST_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and working registers.
  // ---------------------------------------------------------------------------
  state_t state;
  state_t state_next;
  logic   launched;

  logic signed [SPEED_W-1:0] shaft_speed;

  logic [DRIVE_W-1:0]   drive_q;
  logic [POWER_W-1:0]   power_q;
  status_t              status_q;
  logic [EFF_MAG_W-1:0] eff_mag;
  logic [OP_W-1:0]      tgt_mag;
  logic [OP_W-1:0]      step_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic [OP_W-1:0]      thr_mag;
  logic [PROD_W-1:0]    qa;

  // Shared arithmetic units.
  logic              mul_start;
  logic              mul_done;
  logic [OP_W-1:0]   mul_a;
  logic [OP_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_product;
  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] div_dividend;
  logic [OP_W-1:0]   div_divisor;
  logic [OP_W-1:0]   div_quotient;
  logic [OP_W-1:0]   div_remainder;
  logic              out_load;

  ssrt_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  ssrt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // ---------------------------------------------------------------------------
  // Acceptance checks. Configuration and command problems take priority over a
  // shaft speed outside its limits, and a zero tick length is checked last.
  // ---------------------------------------------------------------------------
  logic                      cfg_zero;
  logic                      cmd_bad;
  logic                      spd_bad;
  logic signed [SPEED_W:0]   cur_ext;
  logic signed [SPEED_W:0]   fwd_lim;
  logic signed [SPEED_W:0]   rev_lim;
  status_t                   status_c;

  assign cur_ext = {shaft_speed[SPEED_W-1], shaft_speed};
  assign fwd_lim = $signed({2'b00, max_forward_speed, {RPM_FRAC_W{1'b0}}});
  assign rev_lim = -$signed({2'b00, max_reverse_speed, {RPM_FRAC_W{1'b0}}});

  assign cfg_zero = (max_forward_speed == '0) || (max_reverse_speed == '0) ||
                    (max_forward_thrust == '0) || (max_reverse_thrust == '0) ||
                    (spin_up_rate == '0) || (spin_down_rate == '0);
  assign cmd_bad  = (requested_drive < DRIVE_MIN) || (requested_drive > DRIVE_MAX) ||
                    (available_power > POWER_MAX);
  assign spd_bad  = (cur_ext > fwd_lim) || (cur_ext < rev_lim);

  always_comb begin
    if (cfg_zero) begin
      status_c = STAT_BAD_CFG;
    end else if (cmd_bad) begin
      status_c = STAT_BAD_CMD;
    end else if (spd_bad) begin
      status_c = STAT_BAD_SPEED;
    end else if (tick_length == '0) begin
      status_c = STAT_BAD_CFG;
    end else begin
      status_c = STAT_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // Slew logic. The drive sign carries the target's sign; the target magnitude
  // was already truncated toward zero by working on magnitudes.
  // ---------------------------------------------------------------------------
  logic                       eff_neg;
  logic [DRIVE_W-1:0]         drive_abs;
  logic [SPEED_W-1:0]         tgt_ext;
  logic signed [SPEED_W-1:0]  tgt_s;
  logic [SPEED_W-1:0]         cur_abs;
  logic                       cur_pos;
  logic                       tgt_pos;
  logic                       tgt_neg;
  logic                       reversing;
  logic                       growing;
  logic signed [SPEED_W-1:0]  goal;
  logic signed [SPEED_W:0]    goal_ext;
  logic signed [SPEED_W:0]    diff;
  logic [SPEED_W:0]           diff_abs;
  logic [SPEED_W:0]           step_ext;
  logic                       near;
  logic signed [SPEED_W:0]    next_ext;
  logic signed [SPEED_W-1:0]  next_c;

  assign eff_neg   = drive_q[DRIVE_W-1];
  assign drive_abs = eff_neg ? (~drive_q + 1'b1) : drive_q;
  assign tgt_ext   = {1'b0, tgt_mag};
  assign tgt_s     = eff_neg ? $signed(~tgt_ext + 1'b1) : $signed(tgt_ext);

  assign cur_abs   = shaft_speed[SPEED_W-1] ? (~shaft_speed + 1'b1) : shaft_speed;
  assign cur_pos   = !shaft_speed[SPEED_W-1] && (shaft_speed != '0);
  assign tgt_pos   = !eff_neg && (tgt_mag != '0);
  assign tgt_neg   = eff_neg && (tgt_mag != '0);

  // Across a sign reversal the shaft first has to come down to standstill.
  assign reversing = (cur_pos && tgt_neg) || (shaft_speed[SPEED_W-1] && tgt_pos);
  assign growing   = !reversing && (tgt_ext > cur_abs);
  assign goal      = reversing ? '0 : tgt_s;

  assign goal_ext  = {goal[SPEED_W-1], goal};
  assign diff      = goal_ext - cur_ext;
  assign diff_abs  = diff[SPEED_W] ? (~diff + 1'b1) : diff;
  assign step_ext  = {2'b00, step_q};
  assign near      = diff_abs <= step_ext;
  assign next_ext  = near ? goal_ext :
                     (diff[SPEED_W] ? (cur_ext - $signed(step_ext))
                                    : (cur_ext + $signed(step_ext)));
  assign next_c    = next_ext[SPEED_W-1:0];

  // ---------------------------------------------------------------------------
  // Thrust operands. The thrust is floor(t * a * a / (l * l)) with a the speed
  // magnitude and l the speed limit in 1/256 rpm; it is computed as
  // ((x / l) * a + ((x % l) * a) / l) / l with x = t * a, which keeps every
  // dividend below l * 2^24.
  // ---------------------------------------------------------------------------
  logic                thr_neg;
  logic [SPEED_W-1:0]  speed_abs;
  logic [OP_W-1:0]     thr_a;
  logic [OP_W-1:0]     thr_t;
  logic [OP_W-1:0]     thr_l;

  assign thr_neg   = speed_q[SPEED_W-1];
  assign speed_abs = thr_neg ? (~speed_q + 1'b1) : speed_q;
  assign thr_a     = speed_abs[OP_W-1:0];
  assign thr_t     = thr_neg ? max_reverse_thrust : max_forward_thrust;
  assign thr_l     = {(thr_neg ? max_reverse_speed : max_forward_speed), {RPM_FRAC_W{1'b0}}};

  // ---------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = (status_c == STAT_OK) ? S_EFF : S_DONE;
        end
      end
      S_EFF:    if (mul_done) state_next = S_TGT;
      S_TGT:    if (mul_done) state_next = S_STEP;
      S_STEP:   if (mul_done) state_next = S_NEXT;
      S_NEXT:   state_next = (next_c == '0) ? S_DONE : S_TH_X;
      S_TH_X:   if (mul_done) state_next = S_TH_Q1;
      S_TH_Q1:  if (div_done) state_next = S_TH_QA;
      S_TH_QA:  if (mul_done) state_next = S_TH_RA;
      S_TH_RA:  if (mul_done) state_next = S_TH_RD;
      S_TH_RD:  if (div_done) state_next = S_TH_SUM;
      S_TH_SUM: if (div_done) state_next = S_DONE;
      S_DONE: begin
        if (!res_valid || !res_stall) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs: operand selection and unit launches. Each arithmetic
  // state launches its unit once, in its first cycle.
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_start    = 1'b0;
    div_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_dividend = '0;
    div_divisor  = thr_l;
    cmd_stall    = 1'b1;
    out_load     = 1'b0;
    unique case (state)
      S_IDLE: cmd_stall = 1'b0;
      S_EFF: begin
        mul_a     = OP_W'(drive_abs);
        mul_b     = OP_W'(power_q);
        mul_start = !launched;
      end
      S_TGT: begin
        mul_a     = OP_W'(eff_mag);
        mul_b     = OP_W'(eff_neg ? max_reverse_speed : max_forward_speed);
        mul_start = !launched;
      end
      S_STEP: begin
        mul_a     = OP_W'(growing ? spin_up_rate : spin_down_rate);
        mul_b     = tick_length;
        mul_start = !launched;
      end
      S_TH_X: begin
        mul_a     = thr_t;
        mul_b     = thr_a;
        mul_start = !launched;
      end
      S_TH_Q1: begin
        div_dividend = mul_product;
        div_start    = !launched;
      end
      S_TH_QA: begin
        mul_a     = div_quotient;
        mul_b     = thr_a;
        mul_start = !launched;
      end
      S_TH_RA: begin
        mul_a     = div_remainder;
        mul_b     = thr_a;
        mul_start = !launched;
      end
      S_TH_RD: begin
        div_dividend = mul_product;
        div_start    = !launched;
      end
      S_TH_SUM: begin
        div_dividend = qa + PROD_W'(div_quotient);
        div_start    = !launched;
      end
      S_DONE: out_load = !res_valid || !res_stall;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      launched    <= 1'b0;
      shaft_speed <= '0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_done || div_done) begin
        launched <= 1'b0;
      end else if (mul_start || div_start) begin
        launched <= 1'b1;
      end
      // The state only moves on a word that passed every check.
      if (state == S_NEXT) begin
        shaft_speed <= next_c;
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Working data. Results are cleared on acceptance so that a word that fails
  // its checks reports zeros without a separate path.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      drive_q  <= requested_drive;
      power_q  <= available_power;
      status_q <= status_c;
      eff_mag  <= '0;
      tgt_mag  <= '0;
      speed_q  <= '0;
      thr_mag  <= '0;
    end
    if (state == S_EFF && mul_done) begin
      eff_mag <= mul_product[FRAC_W +: EFF_MAG_W];
    end
    if (state == S_TGT && mul_done) begin
      tgt_mag <= mul_product[TGT_SHIFT +: OP_W];
    end
    if (state == S_STEP && mul_done) begin
      step_q <= mul_product[STEP_SHIFT +: OP_W];
    end
    if (state == S_NEXT) begin
      speed_q <= next_c;
    end
    if (state == S_TH_QA && mul_done) begin
      qa <= mul_product;
    end
    if (state == S_TH_SUM && div_done) begin
      thr_mag <= div_quotient;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word register; it holds while the downstream side stalls.
  // ---------------------------------------------------------------------------
  logic [DRIVE_W-1:0] eff_ext;
  logic [SPEED_W-1:0] thr_ext;

  assign eff_ext = {1'b0, eff_mag};
  assign thr_ext = {1'b0, thr_mag};

  always_ff @(posedge clk) begin
    if (out_load) begin
      next_speed      <= speed_q;
      effective_drive <= eff_neg ? $signed(~eff_ext + 1'b1) : $signed(eff_ext);
      target_speed    <= tgt_s;
      thrust          <= thr_neg ? $signed(~thr_ext + 1'b1) : $signed(thr_ext);
      status          <= status_q;
    end
  end

endmodule

// File: rtl/ssrt_mul.sv
`timescale 1ns / 1ps

// Radix-2 shift-add multiplier: the multiplier operand shifts out one bit per
// cycle and the partial product shifts in from the top, so only an
// OP_W-bit adder is needed.
module ssrt_mul import ssrt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OP_W-1:0]   op_a,
  input  logic [OP_W-1:0]   op_b,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic [OP_W-1:0]  mcand;
  logic [OP_W-1:0]  hi;
  logic [OP_W-1:0]  lo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [OP_W:0]    sum;

  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(OP_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= op_a;
      hi    <= '0;
      lo    <= op_b;
    end else if (busy) begin
      hi <= sum[OP_W:1];
      lo <= {sum[0], lo[OP_W-1:1]};
    end
  end

endmodule

// File: rtl/ssrt_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend must be below
// divisor * 2^OP_W so that the quotient fits in OP_W bits.
module ssrt_div import ssrt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [OP_W-1:0]   divisor,
  output logic              done,
  output logic [OP_W-1:0]   quotient,
  output logic [OP_W-1:0]   remainder
);

  logic [OP_W-1:0]  rem;
  logic [OP_W-1:0]  quo;
  logic [OP_W-1:0]  dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [OP_W:0]    trial;
  logic [OP_W:0]    diff;
  logic             fits;

  assign trial     = {rem, quo[OP_W-1]};
  assign diff      = trial - {1'b0, dsr};
  assign fits      = !diff[OP_W];
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(OP_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[PROD_W-1:OP_W];
      quo <= dividend[OP_W-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[OP_W-1:0] : trial[OP_W-1:0];
      quo <= {quo[OP_W-2:0], fits};
    end
  end

endmodule
